// ===== rtl/core/ild_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ild_pkg;

    localparam int WindowDepthDefault = 8192;

    typedef enum logic [1:0] {
        CMD_FEED    = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MORE = 2'd1,
        ST_DONE = 2'd2,
        ST_ERR  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_INIT  = 3'd0,
        PH_FLAG  = 3'd1,
        PH_LIT   = 3'd2,
        PH_MATCH = 3'd3,
        PH_COPY  = 3'd4,
        PH_ERR   = 3'd5
    } phase_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INIT,
        S_SAVE,
        S_FLAG,
        S_LIT_CODE,
        S_MLEN_PFX,
        S_MLEN_EXT,
        S_DIST_PFX,
        S_DIST_EXT,
        S_SHORT_SEL,
        S_SHORT_EXT,
        S_FINISH,
        S_READ,
        S_EMIT
    } ctrl_state_t;

    // Datapath operation selected by the controller in each cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_FEED,
        OP_RESTART,
        OP_LOAD_FIRST,
        OP_SAVE,
        OP_FLAG_BIT,
        OP_LIT_BITS,
        OP_MLEN_BIT,
        OP_MLEN_BITS,
        OP_DIST_BIT,
        OP_DIST_BITS,
        OP_SHORT_BIT,
        OP_SHORT_BITS,
        OP_FINISH,
        OP_READ,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic    starved;     // a bit read since the save found no control word
        logic    bits_done;   // a multi-bit field is complete
        logic    bit_val;     // value of the bit just read
        logic    lit_more;    // literal escape code needs the next table row
        logic    mlen_stop;   // match length prefix is complete
        logic    len_zero;    // match length value (base plus extra) is zero
        logic    dist_stop;   // distance prefix is complete
        logic    queue_full;
        logic    queue_empty;
        logic    left_zero;
        logic    literal;
        phase_t  phase;
        status_t fin_status;
    } dp_status_t;

    function automatic logic [3:0] lit_bits_f(input logic [2:0] t);
        case (t)
            3'd0: lit_bits_f = 4'd1;
            3'd1: lit_bits_f = 4'd2;
            3'd2: lit_bits_f = 4'd2;
            3'd3: lit_bits_f = 4'd3;
            3'd4: lit_bits_f = 4'd8;
            default: lit_bits_f = 4'd15;
        endcase
    endfunction

    function automatic logic [15:0] lit_max_f(input logic [2:0] t);
        case (t)
            3'd0: lit_max_f = 16'd1;
            3'd1: lit_max_f = 16'd3;
            3'd2: lit_max_f = 16'd3;
            3'd3: lit_max_f = 16'd7;
            3'd4: lit_max_f = 16'd255;
            default: lit_max_f = 16'd32768;
        endcase
    endfunction

    function automatic logic [15:0] lit_base_f(input logic [2:0] t);
        case (t)
            3'd0: lit_base_f = 16'd1;
            3'd1: lit_base_f = 16'd2;
            3'd2: lit_base_f = 16'd5;
            3'd3: lit_base_f = 16'd8;
            3'd4: lit_base_f = 16'd15;
            default: lit_base_f = 16'd270;
        endcase
    endfunction

    function automatic logic [3:0] mlen_extra_f(input logic [2:0] t);
        case (t)
            3'd0: mlen_extra_f = 4'd0;
            3'd1: mlen_extra_f = 4'd0;
            3'd2: mlen_extra_f = 4'd1;
            3'd3: mlen_extra_f = 4'd2;
            default: mlen_extra_f = 4'd10;
        endcase
    endfunction

    function automatic logic [3:0] mlen_base_f(input logic [2:0] t);
        case (t)
            3'd0: mlen_base_f = 4'd0;
            3'd1: mlen_base_f = 4'd1;
            3'd2: mlen_base_f = 4'd2;
            3'd3: mlen_base_f = 4'd4;
            default: mlen_base_f = 4'd8;
        endcase
    endfunction

    function automatic logic [3:0] dist_extra_f(input logic [1:0] t);
        case (t)
            2'd0: dist_extra_f = 4'd8;
            2'd1: dist_extra_f = 4'd5;
            default: dist_extra_f = 4'd12;
        endcase
    endfunction

    function automatic logic [8:0] dist_base_f(input logic [1:0] t);
        case (t)
            2'd0: dist_base_f = 9'd32;
            2'd1: dist_base_f = 9'd0;
            default: dist_base_f = 9'd288;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ice_lz_backward_depacker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ice 2.1 backward depacker. Packed bytes go in with cmd 0, a restart with
// cmd 2 loads output_length, and each cmd 1 returns one result: an unpacked
// byte (status 0) or a status of more input needed, finished or overrun.
// Feed and restart are taken while idle; a request is answered by a status
// alone, a literal byte or a copied byte, and a unit header is decoded first
// when one is due. The prefix codes are read one bit per cycle by the
// controller, and a copied byte needs one registered read of the history RAM
// (8K entries by default). The input is held off while a result waits.
module ice_lz_backward_depacker_core
    import ild_pkg::*;
#(
    parameter int WINDOW_DEPTH = WindowDepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] packed_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [23:0] output_length_reg;
    dp_cmd_t     cmd;
    dp_status_t  st;
    logic [7:0]  emit_byte, out_byte_reg;
    logic        emit_last, last_reg, m_emit, cap;
    logic [1:0]  m_status;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {8'd0, output_length_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_length_reg <= '0;
        end else if (psel && penable && pwrite && paddr == 3'd0) begin
            output_length_reg <= pwdata[23:0];
        end
    end

    ild_controller u_ctrl (
        .aclk, .aresetn,
        .s_valid(s_tvalid), .s_ready(s_tready), .s_cmd(s_tuser),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_status, .m_emit,
        .cmd, .st
    );

    ild_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .aclk, .aresetn, .cmd, .feed_byte(s_tdata),
        .output_length(output_length_reg), .status(st), .emit_byte, .emit_last
    );

    assign cap = cmd.op == OP_EMIT;
    always_ff @(posedge aclk) begin
        if (cap) begin
            out_byte_reg <= emit_byte;
            last_reg <= emit_last;
        end
    end

    assign m_tdata = m_emit ? out_byte_reg : 8'd0;
    assign m_tuser = m_status;
    assign m_tlast = m_emit & last_reg;
endmodule
`default_nettype wire

// ===== rtl/core/ild_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ild_datapath
    import ild_pkg::*;
#(
    parameter int WINDOW_DEPTH = WindowDepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    input  wire logic [7:0]  feed_byte,
    input  wire logic [23:0] output_length,
    output dp_status_t       status,
    output logic [7:0]       emit_byte,
    output logic             emit_last
);
    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int CW = PW + 1;

    logic [7:0] window_mem [WINDOW_DEPTH];
    logic [7:0] rd_data_reg;

    logic [31:0] cw_reg, cw_next, wa_reg, wa_next;
    logic [31:0] bm_reg, bm_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] s_cw_reg, s_bm_reg, s_wa_reg;
    logic [2:0]  s_cnt_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] run_reg, run_next;
    logic [16:0] dist_reg, dist_next;
    logic [23:0] left_reg, left_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [CW-1:0] prod_reg, prod_next;
    logic        starved_reg, starved_next;
    logic        literal_reg, literal_next;
    logic [2:0]  t_reg, t_next;
    logic [3:0]  n_reg, n_next;
    logic [15:0] v_reg, v_next;
    logic [15:0] len_reg, len_next;
    logic [12:0] pos_reg, pos_next;
    logic        bit_val_reg, bit_val_next;
    logic        zero_ok_reg, zero_ok_next;

    // Bit reader.
    logic        rb;
    logic        rb_starve;
    logic [31:0] rb_cw, rb_bm, rb_wa;
    logic [2:0]  rb_cnt;
    always_comb begin
        rb_cw = cw_reg;
        rb_bm = bm_reg;
        rb_wa = wa_reg;
        rb_cnt = cnt_reg;
        rb_starve = 1'b0;
        rb = 1'b0;
        if (bm_reg == 32'd0) begin
            if (cnt_reg < 3'd4) begin
                rb_starve = 1'b1;
            end else begin
                rb_cw = wa_reg;
                rb_wa = 32'd0;
                rb_cnt = 3'd0;
                rb_bm = 32'h8000_0000;
            end
        end
        if (!rb_starve) begin
            rb = (rb_cw & rb_bm) != 32'd0;
            rb_bm = rb_bm >> 1;
        end
    end

    logic [15:0] v_shift;
    assign v_shift = {v_reg[14:0], rb};

    // First word marker search.
    logic [4:0]  k;
    logic [31:0] wsh;
    always_comb begin
        k = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (wa_reg[i]) k = 5'(i);
        end
        wsh = wa_reg >> k;
    end

    logic [PW-1:0] rd_addr;
    assign rd_addr = wp_reg - dist_reg[PW-1:0];
    logic rd_ok;
    assign rd_ok = (dist_reg != 17'd0) && ({{(32-CW){1'b0}}, prod_reg} >= 32'(dist_reg))
        && (32'(dist_reg) <= 32'(WINDOW_DEPTH));

    logic [7:0] emit_val;
    logic [16:0] dist_sum;
    always_comb begin
        emit_val = 8'd0;
        if (phase_reg == PH_LIT) emit_val = wa_reg[7:0];
        else if (zero_ok_reg) emit_val = rd_data_reg;
    end
    assign dist_sum = 17'(len_reg) + 17'(pos_reg) + 17'd2;

    always_comb begin
        cw_next = cw_reg; bm_next = bm_reg; wa_next = wa_reg; cnt_next = cnt_reg;
        phase_next = phase_reg; run_next = run_reg; dist_next = dist_reg;
        left_next = left_reg; wp_next = wp_reg; prod_next = prod_reg;
        starved_next = starved_reg; literal_next = literal_reg;
        t_next = t_reg; n_next = n_reg; v_next = v_reg; len_next = len_reg;
        pos_next = pos_reg; bit_val_next = bit_val_reg; zero_ok_next = zero_ok_reg;
        unique case (cmd.op)
            OP_FEED: begin
                if (cnt_reg < 3'd4) begin
                    wa_next = wa_reg | ({24'd0, feed_byte} << {cnt_reg[1:0], 3'd0});
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            OP_RESTART: begin
                cw_next = '0; bm_next = '0; wa_next = '0; cnt_next = '0;
                phase_next = PH_INIT; run_next = '0; dist_next = '0;
                left_next = output_length; wp_next = '0; prod_next = '0;
            end
            OP_LOAD_FIRST: begin
                wa_next = '0;
                cnt_next = '0;
                if (wa_reg == 32'd0 || k == 5'd31) begin
                    cw_next = '0;
                    bm_next = '0;
                end else begin
                    cw_next = wsh >> 1;
                    bm_next = 32'd1 << (5'd30 - k);
                end
                phase_next = PH_FLAG;
            end
            OP_SAVE: begin
                starved_next = 1'b0;
                literal_next = 1'b0;
                t_next = '0; v_next = '0; len_next = '0; pos_next = '0;
                n_next = lit_bits_f(3'd0);
                // The match length prefix always reads at least one bit.
                bit_val_next = 1'b1;
            end
            OP_FLAG_BIT, OP_MLEN_BIT, OP_DIST_BIT, OP_SHORT_BIT: begin
                cw_next = rb_cw; bm_next = rb_bm; wa_next = rb_wa; cnt_next = rb_cnt;
                starved_next = starved_reg | rb_starve;
                bit_val_next = rb;
                v_next = '0;
                if (cmd.op == OP_FLAG_BIT) begin
                    literal_next = rb;
                    bit_val_next = bit_val_reg;
                end else if (cmd.op == OP_MLEN_BIT) begin
                    if (rb) t_next = t_reg + 3'd1;
                    if (!rb || t_reg == 3'd3) begin
                        n_next = mlen_extra_f(rb ? t_reg + 3'd1 : t_reg);
                    end
                end else if (cmd.op == OP_DIST_BIT) begin
                    if (rb) t_next = t_reg + 3'd1;
                    if (!rb || t_reg == 3'd1) begin
                        n_next = dist_extra_f(rb ? t_reg[1:0] + 2'd1 : t_reg[1:0]);
                    end
                end else begin
                    n_next = rb ? 4'd9 : 4'd6;
                end
            end
            OP_LIT_BITS, OP_MLEN_BITS, OP_DIST_BITS, OP_SHORT_BITS: begin
                if (n_reg != 4'd0) begin
                    cw_next = rb_cw; bm_next = rb_bm; wa_next = rb_wa; cnt_next = rb_cnt;
                    starved_next = starved_reg | rb_starve;
                    v_next = v_shift;
                    n_next = n_reg - 4'd1;
                end
                if (n_reg <= 4'd1) begin
                    logic [15:0] vf;
                    vf = (n_reg == 4'd0) ? v_reg : v_shift;
                    v_next = '0;
                    unique case (cmd.op)
                        OP_LIT_BITS: begin
                            if (vf != lit_max_f(t_reg) || t_reg == 3'd5) begin
                                len_next = vf + lit_base_f(t_reg);
                            end else begin
                                t_next = t_reg + 3'd1;
                                n_next = lit_bits_f(t_reg + 3'd1);
                            end
                        end
                        OP_MLEN_BITS: begin
                            len_next = 16'(mlen_base_f(t_reg)) + vf;
                            t_next = '0;
                        end
                        OP_DIST_BITS: pos_next = 13'(dist_base_f(t_reg[1:0])) + vf[12:0];
                        default: pos_next = bit_val_reg ? vf[12:0] + 13'd64 : vf[12:0];
                    endcase
                end
            end
            OP_FINISH: begin
                if (starved_reg) begin
                    cw_next = s_cw_reg; bm_next = s_bm_reg;
                    wa_next = s_wa_reg; cnt_next = s_cnt_reg;
                end else begin
                    logic [15:0] l;
                    l = literal_reg ? len_reg : len_reg + 16'd2;
                    if (24'(l) > left_reg) begin
                        phase_next = PH_ERR;
                    end else begin
                        run_next = l;
                        if (literal_reg) begin
                            phase_next = PH_LIT;
                        end else begin
                            dist_next = dist_sum;
                            phase_next = PH_COPY;
                        end
                    end
                end
            end
            OP_READ: zero_ok_next = rd_ok;
            OP_EMIT: begin
                if (phase_reg == PH_LIT) begin
                    wa_next = wa_reg >> 8;
                    cnt_next = cnt_reg - 3'd1;
                    run_next = run_reg - 16'd1;
                    if (run_reg == 16'd1) phase_next = PH_MATCH;
                end else begin
                    if (run_reg != 16'd0) run_next = run_reg - 16'd1;
                    if (run_reg <= 16'd1) phase_next = PH_FLAG;
                end
                wp_next = (32'(wp_reg) + 32'd1 == 32'(WINDOW_DEPTH)) ? '0 : wp_reg + 1'b1;
                if (32'(prod_reg) < 32'(WINDOW_DEPTH)) prod_next = prod_reg + 1'b1;
                left_next = left_reg - 24'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= '0; bm_reg <= '0; wa_reg <= '0; cnt_reg <= '0;
            phase_reg <= PH_INIT; run_reg <= '0; dist_reg <= '0; left_reg <= '0;
            wp_reg <= '0; prod_reg <= '0; starved_reg <= 1'b0; literal_reg <= 1'b0;
        end else begin
            cw_reg <= cw_next; bm_reg <= bm_next; wa_reg <= wa_next; cnt_reg <= cnt_next;
            phase_reg <= phase_next; run_reg <= run_next; dist_reg <= dist_next;
            left_reg <= left_next; wp_reg <= wp_next; prod_reg <= prod_next;
            starved_reg <= starved_next; literal_reg <= literal_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg <= t_next; n_reg <= n_next; v_reg <= v_next; len_reg <= len_next;
        pos_reg <= pos_next; bit_val_reg <= bit_val_next; zero_ok_reg <= zero_ok_next;
        if (cmd.op == OP_SAVE) begin
            s_cw_reg <= cw_reg; s_bm_reg <= bm_reg; s_wa_reg <= wa_reg; s_cnt_reg <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) window_mem[wp_reg] <= emit_val;
        rd_data_reg <= window_mem[rd_addr];
    end

    assign emit_byte = emit_val;
    assign emit_last = left_reg == 24'd1;

    always_comb begin
        status.starved     = starved_reg;
        status.bits_done   = n_reg <= 4'd1;
        status.bit_val     = bit_val_reg;
        status.lit_more    = (((n_reg == 4'd0) ? v_reg : v_shift) == lit_max_f(t_reg))
                             && t_reg != 3'd5;
        status.mlen_stop   = !bit_val_reg || t_reg == 3'd4;
        status.len_zero    = len_reg == 16'd0;
        status.dist_stop   = !bit_val_reg || t_reg == 3'd2;
        status.queue_full  = cnt_reg >= 3'd4;
        status.queue_empty = cnt_reg == 3'd0;
        status.left_zero   = left_reg == 24'd0;
        status.literal     = literal_reg;
        status.phase       = phase_reg;
        status.fin_status  = starved_reg ? ST_MORE :
            (24'(literal_reg ? len_reg : len_reg + 16'd2) > left_reg) ? ST_ERR : ST_OK;
    end
endmodule
`default_nettype wire

// ===== rtl/core/ild_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ild_controller
    import ild_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_cmd,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_status,
    output logic            m_emit,
    output dp_cmd_t         cmd,
    input  wire dp_status_t st
);
    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic        m_emit_reg, m_emit_next;
    logic        bit_read;

    assign s_ready  = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_emit   = m_emit_reg;
    assign bit_read = st.bits_done;

    // Next state and result register.
    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_emit_next = m_emit_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready && cmd_t'(s_cmd) == CMD_REQUEST) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (st.phase == PH_ERR || st.left_zero) begin
                    m_valid_next = 1'b1; m_emit_next = 1'b0;
                    m_status_next = st.phase == PH_ERR ? ST_ERR : ST_DONE;
                    state_next = S_IDLE;
                end else begin
                    unique case (st.phase)
                        PH_INIT: begin
                            if (!st.queue_full) begin
                                m_valid_next = 1'b1; m_emit_next = 1'b0;
                                m_status_next = ST_MORE; state_next = S_IDLE;
                            end else begin
                                state_next = S_INIT;
                            end
                        end
                        PH_FLAG, PH_MATCH: state_next = S_SAVE;
                        PH_LIT: begin
                            if (st.queue_empty) begin
                                m_valid_next = 1'b1; m_emit_next = 1'b0;
                                m_status_next = ST_MORE; state_next = S_IDLE;
                            end else begin
                                state_next = S_EMIT;
                            end
                        end
                        PH_COPY: state_next = S_READ;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT: state_next = S_DISPATCH;
            S_SAVE: state_next = (st.phase == PH_FLAG) ? S_FLAG : S_MLEN_PFX;
            S_FLAG: state_next = S_LIT_CODE;
            S_LIT_CODE: begin
                if (!st.literal) state_next = S_MLEN_PFX;
                else if (bit_read && !st.lit_more) state_next = S_FINISH;
            end
            S_MLEN_PFX: if (st.mlen_stop) state_next = S_MLEN_EXT;
            S_MLEN_EXT: if (bit_read) state_next = S_SHORT_SEL;
            S_SHORT_SEL: state_next = st.len_zero ? S_SHORT_EXT : S_DIST_PFX;
            S_DIST_PFX: if (st.dist_stop) state_next = S_DIST_EXT;
            S_DIST_EXT: if (bit_read) state_next = S_FINISH;
            S_SHORT_EXT: if (bit_read) state_next = S_FINISH;
            S_FINISH: begin
                if (st.fin_status != ST_OK) begin
                    m_valid_next = 1'b1; m_emit_next = 1'b0;
                    m_status_next = st.fin_status; state_next = S_IDLE;
                end else begin
                    state_next = S_DISPATCH;
                end
            end
            S_READ: state_next = S_EMIT;
            S_EMIT: begin
                m_valid_next = 1'b1; m_emit_next = 1'b1;
                m_status_next = ST_OK; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (cmd_t'(s_cmd))
                        CMD_FEED:    cmd.op = OP_FEED;
                        CMD_RESTART: cmd.op = OP_RESTART;
                        default:     cmd.op = OP_NONE;
                    endcase
                end
            end
            S_INIT:      cmd.op = OP_LOAD_FIRST;
            S_SAVE:      cmd.op = OP_SAVE;
            S_FLAG:      cmd.op = OP_FLAG_BIT;
            S_LIT_CODE:  cmd.op = st.literal ? OP_LIT_BITS : OP_NONE;
            S_MLEN_PFX:  cmd.op = st.mlen_stop ? OP_NONE : OP_MLEN_BIT;
            S_MLEN_EXT:  cmd.op = OP_MLEN_BITS;
            S_SHORT_SEL: cmd.op = st.len_zero ? OP_SHORT_BIT : OP_DIST_BIT;
            S_DIST_PFX:  cmd.op = st.dist_stop ? OP_NONE : OP_DIST_BIT;
            S_DIST_EXT:  cmd.op = OP_DIST_BITS;
            S_SHORT_EXT: cmd.op = OP_SHORT_BITS;
            S_FINISH:    cmd.op = OP_FINISH;
            S_READ:      cmd.op = OP_READ;
            S_EMIT:      cmd.op = OP_EMIT;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            m_status_reg <= ST_OK;
            m_emit_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            m_status_reg <= m_status_next;
            m_emit_reg <= m_emit_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ild_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ild_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_last_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == 2'd0)
        else $error("last on a status result");
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 2'd0 |-> m_tdata == 8'd0)
        else $error("byte set on a status result");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result waits");
endmodule

bind ice_lz_backward_depacker_core ild_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .m_tlast
);
`default_nettype wire
